[hdl/ffea_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_pkg - shared definitions of the first-fit extent allocator
// Opcodes, status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package ffea_pkg;

  parameter int MAX_GAPS_DEFAULT  = 64;
  parameter int ADDR_BITS_DEFAULT = 48;

  parameter int FIELD_BITS     = 48;
  parameter int S_TDATA_BITS   = 3 * FIELD_BITS;
  parameter int S_TUSER_BITS   = 2;
  parameter int M_TDATA_BITS   = FIELD_BITS;
  parameter int M_TUSER_BITS   = 3;
  parameter int IU_LOG2_BITS   = 5;
  parameter int IU_LOG2_RESET  = 12;
  parameter int IU_LOG2_MAX    = 16;
  parameter int SLOT_MIN_LOG2  = 12;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_LIVE   = 2'd1,
    OP_FINISH = 2'd2,
    OP_ALLOC  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ORDER    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

endpackage
`default_nettype wire

[hdl/first_fit_extent_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core - first-fit free extent allocator
// One beat in gives one beat out. A build pass (begin, live extents in
// ascending order, finish) fills a gap table held in a synchronous memory;
// allocate takes the first gap large enough, else appends at the cursor.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Begin and live go through the execute
// state to the output state; finish adds a finish state, allocate a scan
// state reading gap entries until a fit is found or all are read: the gap
// memory has one read port and is read one entry a cycle, the compare in
// the cycle after the read. An allocate whose rounded length overflows skips
// the scan. A result beat left waiting does not stop the next input beat
// being taken, but that item then holds in its output stage until the
// waiting beat leaves. The user must write iu_log2 through cfg_we and
// cfg_wdata while idle, which is not enforced; values above 16 act as 16.
module first_fit_extent_allocator_core #(
  parameter int MAX_GAPS  = ffea_pkg::MAX_GAPS_DEFAULT,
  parameter int ADDR_BITS = ffea_pkg::ADDR_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ffea_pkg::IU_LOG2_BITS-1:0] cfg_wdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // addr_in [47:0], length_in [95:48], store_size [143:96]
  input  wire logic [ffea_pkg::S_TDATA_BITS-1:0] s_tdata,
  // op [1:0]
  input  wire logic [ffea_pkg::S_TUSER_BITS-1:0] s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // addr_out [47:0]
  output logic [ffea_pkg::M_TDATA_BITS-1:0]      m_tdata,
  // from_gap [0], status [2:1]
  output logic [ffea_pkg::M_TUSER_BITS-1:0]      m_tuser
);

  localparam int AW = ADDR_BITS;
  localparam int FB = ffea_pkg::FIELD_BITS;
  localparam int IW = $clog2(MAX_GAPS);
  localparam int CW = $clog2(MAX_GAPS + 1);

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    FIN,
    SCAN,
    OUT
  } state_t;

  state_t               state;
  ffea_pkg::op_t        op_r;
  logic [AW-1:0]        a_r;
  logic [AW-1:0]        l_r;
  logic [AW-1:0]        f_r;
  logic [ffea_pkg::IU_LOG2_BITS-1:0] iu_log2;
  logic [CW-1:0]        gap_count;
  logic [AW-1:0]        scan_end;
  logic [AW-1:0]        last_live;
  logic [AW-1:0]        append_cursor;
  logic [AW-1:0]        rnd_r;
  logic                 rnd_ok;
  logic [CW-1:0]        idx;
  logic [IW-1:0]        pidx;
  logic                 pend;
  logic [AW-1:0]        res_addr;
  logic                 res_gap;
  ffea_pkg::status_t    res_status;

  logic [2*AW-1:0]      gap_mem [MAX_GAPS];
  logic [2*AW-1:0]      mem_q;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [2*AW-1:0]      mem_wdata;
  logic                 mem_re;

  logic [AW+FB-1:0]     ext_a;
  logic [AW+FB-1:0]     ext_l;
  logic [AW+FB-1:0]     ext_f;
  logic [AW+FB-1:0]     ext_out;

  logic [ffea_pkg::IU_LOG2_BITS-1:0] lg;
  logic [ffea_pkg::IU_LOG2_BITS-1:0] base_sh;
  logic [AW-1:0]        iu_lo;
  logic [AW-1:0]        base;
  logic [AW-1:0]        rnd_in;
  logic [AW:0]          rnd_sum;
  logic [AW:0]          live_sum;
  logic                 live_fits;
  logic [AW-1:0]        live_end;
  logic                 ordered;
  logic                 live_gap;
  logic                 room;
  logic                 eof_gap;
  logic [AW-1:0]        rd_start;
  logic [AW-1:0]        rd_len;
  logic                 hit;
  logic                 idx_lt;
  logic [AW:0]          app_sum;

  assign s_tready = (state == IDLE);

  assign ext_a = {{AW{1'b0}}, s_tdata[FB-1:0]};
  assign ext_l = {{AW{1'b0}}, s_tdata[2*FB-1:FB]};
  assign ext_f = {{AW{1'b0}}, s_tdata[3*FB-1:2*FB]};
  assign ext_out = {{FB{1'b0}}, res_addr};

  always_comb begin
    lg = (iu_log2 > ffea_pkg::IU_LOG2_BITS'(ffea_pkg::IU_LOG2_MAX))
       ? ffea_pkg::IU_LOG2_BITS'(ffea_pkg::IU_LOG2_MAX) : iu_log2;
    base_sh = (lg > ffea_pkg::IU_LOG2_BITS'(ffea_pkg::SLOT_MIN_LOG2))
            ? lg : ffea_pkg::IU_LOG2_BITS'(ffea_pkg::SLOT_MIN_LOG2);
    iu_lo = (AW'(1) << lg) - AW'(1);
    base  = AW'(1) << (base_sh + ffea_pkg::IU_LOG2_BITS'(1));

    rnd_in = (op_r == ffea_pkg::OP_FINISH) ? ((f_r < base) ? base : f_r) : l_r;
    rnd_sum = {1'b0, rnd_in} + {1'b0, iu_lo};

    live_sum  = {1'b0, a_r} + {1'b0, l_r};
    live_fits = !live_sum[AW];
    live_end  = live_fits ? live_sum[AW-1:0] : {AW{1'b1}};
    ordered   = (a_r >= last_live);
    live_gap  = ordered && (a_r > scan_end);
    room      = (gap_count < CW'(MAX_GAPS));
    eof_gap   = (rnd_r > scan_end);

    rd_start = mem_q[2*AW-1:AW];
    rd_len   = mem_q[AW-1:0];
    hit      = pend && (rd_len >= rnd_r);
    idx_lt   = (idx < gap_count);
    app_sum  = {1'b0, append_cursor} + {1'b0, rnd_r};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = gap_count[IW-1:0];
    mem_wdata = {scan_end, a_r - scan_end};
    mem_re    = 1'b0;
    case (state)
      EXEC: begin
        mem_we = (op_r == ffea_pkg::OP_LIVE) && live_gap && room;
      end
      FIN: begin
        mem_we    = eof_gap && room;
        mem_wdata = {scan_end, rnd_r - scan_end};
      end
      SCAN: begin
        mem_we    = hit;
        mem_waddr = pidx;
        mem_wdata = {rd_start + rnd_r, rd_len - rnd_r};
        mem_re    = !hit && idx_lt;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= gap_mem[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iu_log2 <= ffea_pkg::IU_LOG2_BITS'(ffea_pkg::IU_LOG2_RESET);
    end else if (cfg_we) begin
      iu_log2 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      gap_count     <= '0;
      scan_end      <= '0;
      last_live     <= '0;
      append_cursor <= '0;
      pend          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            op_r  <= ffea_pkg::op_t'(s_tuser[1:0]);
            a_r   <= ext_a[AW-1:0];
            l_r   <= ext_l[AW-1:0];
            f_r   <= ext_f[AW-1:0];
            state <= EXEC;
          end
        end
        EXEC: begin
          res_addr   <= '0;
          res_gap    <= 1'b0;
          rnd_r      <= rnd_sum[AW] ? ({AW{1'b1}} & ~iu_lo) : (rnd_sum[AW-1:0] & ~iu_lo);
          rnd_ok     <= !rnd_sum[AW];
          idx        <= '0;
          pend       <= 1'b0;
          case (op_r)
            ffea_pkg::OP_BEGIN: begin
              gap_count  <= '0;
              scan_end   <= base;
              last_live  <= '0;
              res_status <= ffea_pkg::ST_OK;
              state      <= OUT;
            end
            ffea_pkg::OP_LIVE: begin
              if (live_gap && room) begin
                gap_count <= gap_count + CW'(1);
              end
              if (ordered) begin
                last_live <= a_r;
              end
              if (live_end > scan_end) begin
                scan_end <= live_end;
              end
              if (!ordered) begin
                res_status <= ffea_pkg::ST_ORDER;
              end else if (!live_fits) begin
                res_status <= ffea_pkg::ST_OVERFLOW;
              end else if (live_gap && !room) begin
                res_status <= ffea_pkg::ST_FULL;
              end else begin
                res_status <= ffea_pkg::ST_OK;
              end
              state <= OUT;
            end
            ffea_pkg::OP_FINISH: begin
              res_status <= ffea_pkg::ST_OK;
              state      <= FIN;
            end
            default: begin
              if (rnd_sum[AW]) begin
                res_status <= ffea_pkg::ST_OVERFLOW;
                state      <= OUT;
              end else begin
                res_status <= ffea_pkg::ST_OK;
                state      <= SCAN;
              end
            end
          endcase
        end
        FIN: begin
          if (eof_gap && room) begin
            gap_count <= gap_count + CW'(1);
          end
          append_cursor <= rnd_r;
          if (!rnd_ok) begin
            res_status <= ffea_pkg::ST_OVERFLOW;
          end else if (eof_gap && !room) begin
            res_status <= ffea_pkg::ST_FULL;
          end
          state <= OUT;
        end
        SCAN: begin
          if (hit) begin
            res_addr <= rd_start;
            res_gap  <= 1'b1;
            pend     <= 1'b0;
            state    <= OUT;
          end else if (idx_lt) begin
            pidx <= idx[IW-1:0];
            pend <= 1'b1;
            idx  <= idx + CW'(1);
          end else begin
            pend <= 1'b0;
            if (app_sum[AW]) begin
              res_status <= ffea_pkg::ST_OVERFLOW;
            end else begin
              res_addr      <= append_cursor;
              append_cursor <= app_sum[AW-1:0];
            end
            state <= OUT;
          end
        end
        OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= ext_out[FB-1:0];
            m_tuser  <= {res_status, res_gap};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/ffea_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_checker - port-level checks of the first-fit extent allocator
// Watches the stream ports of the core; attached by the bind below.
// ----------------------------------------------------------------------------
module ffea_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [ffea_pkg::M_TDATA_BITS-1:0] m_tdata,
  input wire logic [ffea_pkg::M_TUSER_BITS-1:0] m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] != ffea_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("failed op carries a non-zero address");

  a_gap_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tuser[2:1] == ffea_pkg::ST_OK))
    else $error("gap reuse reported with an error status");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input beat taken while an item is in flight");

  a_reset_out: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result beat valid straight after reset");

endmodule

bind first_fit_extent_allocator_core ffea_checker u_ffea_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

[verif/first_fit_extent_allocator_core_tb.sv]
// ----------------------------------------------------------------------------
// First-fit extent allocator core testbench
// A queue-fed stream driver sends build passes (begin, mostly ascending
// live extents with holes, finish) followed by allocations. Every item
// accepted at the input port runs through a behavioural gap table and
// append cursor. The expected grant is then checked, field by field,
// against the output beats. The write unit is changed between passes,
// covering its extremes. Both ports idle at random, and one pass holds
// the output long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [63:0] AMASK = 64'h0000_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct {
    ffea_pkg::op_t op;
    logic [47:0]   addr;
    logic [47:0]   len;
    logic [47:0]   fsize;
  } extent_cmd_t;

  typedef struct {
    logic [47:0]       addr;
    logic              from_gap;
    ffea_pkg::status_t status;
  } grant_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [ffea_pkg::IU_LOG2_BITS-1:0] cfg_wdata = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  // addr_in [47:0], length_in [95:48], store_size [143:96]
  logic [ffea_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
  // op [1:0]
  logic [ffea_pkg::S_TUSER_BITS-1:0] s_tuser = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  // addr_out [47:0]
  logic [ffea_pkg::M_TDATA_BITS-1:0] m_tdata;
  // from_gap [0], status [2:1]
  logic [ffea_pkg::M_TUSER_BITS-1:0] m_tuser;

  extent_cmd_t pending_cmds[$];
  grant_t      expected_grants[$];
  extent_cmd_t offered_cmd;

  logic [63:0] gap_base [ffea_pkg::MAX_GAPS_DEFAULT];
  logic [63:0] gap_size [ffea_pkg::MAX_GAPS_DEFAULT];
  int          gap_used = 0;
  logic [63:0] scan_limit = '0;
  logic [63:0] last_extent = '0;
  logic [63:0] cursor = '0;
  logic [4:0]  iu_cfg = 5'(ffea_pkg::IU_LOG2_RESET);

  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  int rx_hold = 0;
  int tx_idle = 1;
  int rx_idle = 1;
  int random_count = 0;

  first_fit_extent_allocator_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] iu_unit();
    int lg;
    lg = (iu_cfg > ffea_pkg::IU_LOG2_MAX) ? ffea_pkg::IU_LOG2_MAX : int'(iu_cfg);
    return 64'd1 << lg;
  endfunction

  function automatic logic [63:0] store_base();
    logic [63:0] slot;
    slot = (iu_unit() > (64'd1 << ffea_pkg::SLOT_MIN_LOG2))
         ? iu_unit() : (64'd1 << ffea_pkg::SLOT_MIN_LOG2);
    return slot * 2;
  endfunction

  function automatic logic round_up(input logic [63:0] x, output logic [63:0] r);
    logic [63:0] s;
    s = x + iu_unit() - 1;
    if (s > AMASK) begin
      r = AMASK & ~(iu_unit() - 1);
      return 1'b0;
    end
    r = s & ~(iu_unit() - 1);
    return 1'b1;
  endfunction

  function automatic logic record_gap(input logic [63:0] start, input logic [63:0] size);
    if (gap_used >= ffea_pkg::MAX_GAPS_DEFAULT) return 1'b0;
    gap_base[gap_used] = start;
    gap_size[gap_used] = size;
    gap_used++;
    return 1'b1;
  endfunction

  task automatic allocator_step(input extent_cmd_t c);
    grant_t      g;
    logic [63:0] a, l, f, stop, eof, need, nxt;
    logic        ordered, fits, stored, found;
    a = {16'd0, c.addr};
    l = {16'd0, c.len};
    f = {16'd0, c.fsize};
    g.addr = '0;
    g.from_gap = 1'b0;
    g.status = ffea_pkg::ST_OK;
    case (c.op)
      ffea_pkg::OP_BEGIN: begin
        gap_used = 0;
        scan_limit = store_base();
        last_extent = '0;
      end
      ffea_pkg::OP_LIVE: begin
        ordered = a >= last_extent;
        stop = a + l;
        fits = stop <= AMASK;
        if (!fits) stop = AMASK;
        stored = 1'b1;
        if (ordered) begin
          if (a > scan_limit) stored = record_gap(scan_limit, a - scan_limit);
          last_extent = a;
        end
        if (stop > scan_limit) scan_limit = stop;
        if (!ordered) g.status = ffea_pkg::ST_ORDER;
        else if (!fits) g.status = ffea_pkg::ST_OVERFLOW;
        else if (!stored) g.status = ffea_pkg::ST_FULL;
      end
      ffea_pkg::OP_FINISH: begin
        eof = (f < store_base()) ? store_base() : f;
        fits = round_up(eof, eof);
        stored = 1'b1;
        if (eof > scan_limit) stored = record_gap(scan_limit, eof - scan_limit);
        cursor = eof;
        if (!fits) g.status = ffea_pkg::ST_OVERFLOW;
        else if (!stored) g.status = ffea_pkg::ST_FULL;
      end
      default: begin
        if (!round_up(l, need)) begin
          g.status = ffea_pkg::ST_OVERFLOW;
        end else begin
          found = 1'b0;
          for (int i = 0; i < gap_used && !found; i++) begin
            if (gap_size[i] >= need) begin
              g.addr = gap_base[i][47:0];
              gap_base[i] = gap_base[i] + need;
              gap_size[i] = gap_size[i] - need;
              g.from_gap = 1'b1;
              found = 1'b1;
            end
          end
          if (!found) begin
            nxt = cursor + need;
            if (nxt <= AMASK) begin
              g.addr = cursor[47:0];
              cursor = nxt;
            end else begin
              g.status = ffea_pkg::ST_OVERFLOW;
            end
          end
        end
      end
    endcase
    expected_grants.insert(expected_grants.size(), g);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[47:0];
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic queue_cmd(input ffea_pkg::op_t op, input logic [63:0] a,
                           input logic [63:0] l, input logic [63:0] f);
    extent_cmd_t c;
    c.op = op;
    c.addr = a[47:0];
    c.len = l[47:0];
    c.fsize = f[47:0];
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic queue_build(input int n_live);
    logic [63:0] unit, pos, prev, a, l, f;
    int          r, unit_i;
    unit = iu_unit();
    unit_i = int'(unit);
    pos = ($urandom_range(0, 7) == 0) ? 64'd0 : store_base();
    prev = '0;
    queue_cmd(ffea_pkg::OP_BEGIN, rand48(), rand48(), rand48());
    for (int i = 0; i < n_live; i++) begin
      r = $urandom_range(0, 59);
      if (r == 0 && prev != 0) begin
        a = prev >> $urandom_range(1, 4);
        l = unit * $urandom_range(0, 3);
      end else if (r == 1 && n_live < 60) begin
        a = rand48();
        l = rand48();
      end else if (i == n_live - 1 && r < 10) begin
        a = AMASK - $urandom_range(0, 65535);
        l = AMASK - $urandom_range(0, 1000);
      end else begin
        a = pos;
        if ($urandom_range(0, 3) != 0) a = a + unit * $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0) a = a + $urandom_range(0, unit_i - 1);
        l = unit * $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) l = l + $urandom_range(0, unit_i - 1);
      end
      queue_cmd(ffea_pkg::OP_LIVE, a, l, rand48());
      if (a >= prev) prev = a;
      if (a + l > pos) pos = a + l;
    end
    r = $urandom_range(0, 19);
    if (r < 2) f = '0;
    else if (r < 4) f = rand48();
    else if (r == 4) f = AMASK;
    else f = pos + unit * $urandom_range(0, 40) + $urandom_range(0, unit_i - 1);
    queue_cmd(ffea_pkg::OP_FINISH, rand48(), rand48(), f);
  endtask

  task automatic queue_allocs(input int n);
    logic [63:0] unit, l;
    int          r, unit_i;
    unit = iu_unit();
    unit_i = int'(unit);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 29);
      if (r == 3) begin
        queue_cmd(ffea_pkg::op_t'($urandom_range(0, 3)), rand48(), rand48(), rand48());
      end else begin
        if (r == 0) l = '0;
        else if (r == 1) l = rand48();
        else if (r == 2) l = AMASK;
        else begin
          l = unit * $urandom_range(0, 3);
          if ($urandom_range(0, 1) == 0) l = l + $urandom_range(1, unit_i);
        end
        queue_cmd(ffea_pkg::OP_ALLOC, rand48(), l, rand48());
      end
    end
  endtask

  task automatic write_iu(input logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    iu_cfg = v;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || s_tvalid || expected_grants.size() != 0);
    repeat (80) @(negedge clk);
  endtask

  always @(posedge clk) begin : tx_side
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) allocator_step(offered_cmd);
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          offered_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {offered_cmd.fsize, offered_cmd.len, offered_cmd.addr};
          s_tuser <= offered_cmd.op;
          if (tx_idle != 0) tx_gap = idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx_side
    grant_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_grants.size() == 0) begin
          flag_mismatch($sformatf("result beat with none expected, addr %h", m_tdata));
        end else begin
          want = expected_grants.pop_front();
          if (m_tdata !== want.addr)
            flag_mismatch($sformatf("addr_out %h, want %h", m_tdata, want.addr));
          if (m_tuser[0] !== want.from_gap)
            flag_mismatch($sformatf("from_gap %b, want %b", m_tuser[0], want.from_gap));
          if (m_tuser[2:1] !== want.status)
            flag_mismatch($sformatf("status %0d, want %s", m_tuser[2:1], want.status.name()));
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rx_idle != 0 && $urandom_range(0, 4) == 0) rx_stall = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** first_fit_extent_allocator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [4:0] iu_val;
    int         phase;
    int         n_live;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_cmd(ffea_pkg::OP_ALLOC, '0, '0, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, 64'd1, '0);
    queue_cmd(ffea_pkg::OP_BEGIN, AMASK, AMASK, AMASK);
    queue_cmd(ffea_pkg::OP_LIVE, 64'h3000, 64'h1000, '0);
    queue_cmd(ffea_pkg::OP_LIVE, 64'h5000, 64'h801, '0);
    queue_cmd(ffea_pkg::OP_LIVE, 64'h1000, 64'h100, '0);
    queue_cmd(ffea_pkg::OP_FINISH, '0, '0, 64'h10000);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, '0, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, 64'd1, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, '0, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, 64'h2000, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, 64'h100000, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, AMASK, '0);
    queue_cmd(ffea_pkg::OP_BEGIN, '0, '0, '0);
    queue_cmd(ffea_pkg::OP_LIVE, 64'hFFFF_FFFF_0000, AMASK, '0);
    queue_cmd(ffea_pkg::OP_LIVE, 64'h4000, 64'h10, '0);
    queue_cmd(ffea_pkg::OP_FINISH, '0, '0, AMASK);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, 64'hFFFF_FFFF_0000, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, 64'h3000, '0);
    queue_cmd(ffea_pkg::OP_FINISH, '0, '0, '0);
    queue_cmd(ffea_pkg::OP_ALLOC, '0, 64'h1234, '0);
    wait_drained();

    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      case (phase)
        0: iu_val = 5'd0;
        1: iu_val = 5'd16;
        2: iu_val = 5'd31;
        3: iu_val = 5'd12;
        4: iu_val = 5'd17;
        default: iu_val = 5'($urandom_range(0, 31));
      endcase
      write_iu(iu_val);
      @(negedge clk);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (phase == 1) begin
        tx_idle = 0;
        rx_hold = 400;
      end
      if (phase == 1 || $urandom_range(0, 7) == 0) n_live = $urandom_range(80, 100);
      else n_live = $urandom_range(0, 24);
      queue_build(n_live);
      queue_allocs($urandom_range(10, 60));
      random_count += pending_cmds.size();
      wait_drained();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("** first_fit_extent_allocator_core: PASSED **");
    end else begin
      $display("** first_fit_extent_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
